[hdl/svm_pkg.sv]
`default_nettype none
package svm_pkg;
  localparam int VoiceCount = 256;
  localparam int VoiceBits = 8;
  localparam int AddrBits = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic REG_OUT_CHANNELS = 1'b0;
  localparam logic REG_MIX_GAIN     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_TICK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;
    logic                 capture;
    logic                 clear_sums;
    logic                 scan_en;
    logic [VoiceBits-1:0] scan_voice;
    logic                 claim;
    logic                 done;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic active;
    logic pipe_busy;
  } status_t;
endpackage
`default_nettype wire

[hdl/svm_datapath.sv]
`default_nettype none
module svm_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire svm_pkg::cmd_t         cmd,
  output svm_pkg::status_t           status,
  input  wire logic [1:0]            out_channels,
  input  wire logic [15:0]           mix_gain,
  input  wire logic [1:0]            operation,
  input  wire logic [15:0]           load_address,
  input  wire logic signed [15:0]    sample_value,
  input  wire logic [15:0]           sound_base,
  input  wire logic [15:0]           frame_count,
  input  wire logic [3:0]            sound_channels,
  input  wire logic                  loop_flag,
  output logic signed [23:0]         left_sample,
  output logic signed [23:0]         right_sample,
  output logic                       start_accepted,
  output logic [7:0]                 voice_slot,
  output logic [8:0]                 active_voices
);
  import svm_pkg::*;

  logic [15:0] sample_mem [2**AddrBits];
  logic [15:0] base_mem   [VoiceCount];
  logic [15:0] len_mem    [VoiceCount];
  logic [2:0]  chm_mem    [VoiceCount];
  logic [15:0] pos_mem    [VoiceCount];
  logic        loop_mem   [VoiceCount];
  logic [VoiceCount-1:0] active;
  logic [8:0]  live;

  // Captured item.
  logic [1:0]  op_q;
  logic [15:0] base_q, len_q;
  logic [2:0]  chm_q;
  logic        loop_q;
  logic        stereo;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      base_q <= sound_base;
      len_q  <= frame_count;
      if (sound_channels == 4'd0) chm_q <= 3'd0;
      else if (sound_channels > 4'd8) chm_q <= 3'd7;
      else chm_q <= 3'(sound_channels - 4'd1);
      loop_q <= loop_flag;
      stereo <= out_channels[1];
    end
  end

  assign status.active = active[cmd.scan_voice];

  // Stage 1: read voice descriptor.
  logic        s1_v;
  logic [VoiceBits-1:0] s1_voice;
  logic [15:0] s1_base, s1_len, s1_pos;
  logic [2:0]  s1_chm;
  logic        s1_loop;
  always_ff @(posedge clk) begin
    s1_base  <= base_mem[cmd.scan_voice];
    s1_len   <= len_mem[cmd.scan_voice];
    s1_pos   <= pos_mem[cmd.scan_voice];
    s1_chm   <= chm_mem[cmd.scan_voice];
    s1_loop  <= loop_mem[cmd.scan_voice];
    s1_voice <= cmd.scan_voice;
  end

  // Stage 2: address multiply.
  logic        s2_v;
  logic [15:0] s2_frame, s2_next;
  logic [2:0]  s2_chm;
  logic [VoiceBits-1:0] s2_voice;
  logic        s2_end, s2_loop;
  logic [16:0] pos_inc;
  assign pos_inc = {1'b0, s1_pos} + 17'd1;
  always_ff @(posedge clk) begin
    s2_frame <= 16'(s1_base + 16'(s1_pos * {13'd0, s1_chm} + s1_pos));
    s2_chm   <= s1_chm;
    s2_voice <= s1_voice;
    s2_end   <= pos_inc >= {1'b0, s1_len};
    s2_loop  <= s1_loop;
    s2_next  <= pos_inc[15:0];
  end

  // Stage 3: sample reads, two port reads per voice.
  logic        s3_v;
  logic signed [15:0] s3_l, s3_r;
  always_ff @(posedge clk) begin
    s3_l <= sample_mem[s2_frame];
    s3_r <= sample_mem[16'(s2_frame + ((s2_chm != 3'd0) ? 16'd1 : 16'd0))];
  end

  // Stage 4: gain products.
  logic        s4_v;
  logic signed [32:0] s4_pl, s4_pr;
  always_ff @(posedge clk) begin
    s4_pl <= s3_l * $signed({1'b0, mix_gain});
    s4_pr <= s3_r * $signed({1'b0, mix_gain});
  end

  logic signed [25:0] sum_l, sum_r;
  always_ff @(posedge clk) begin
    if (cmd.clear_sums) begin
      sum_l <= '0;
      sum_r <= '0;
    end else if (s4_v) begin
      sum_l <= sum_l + 26'(s4_pl >>> 16);
      sum_r <= sum_r + 26'(s4_pr >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= cmd.scan_en && active[cmd.scan_voice];
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end
  assign status.pipe_busy = s1_v | s2_v | s3_v | s4_v;

  // Memory writes.
  always_ff @(posedge clk) begin
    if (cmd.load) sample_mem[load_address] <= sample_value;
    if (cmd.claim) begin
      base_mem[cmd.scan_voice] <= base_q;
      len_mem[cmd.scan_voice]  <= len_q;
      chm_mem[cmd.scan_voice]  <= chm_q;
      loop_mem[cmd.scan_voice] <= loop_q;
      pos_mem[cmd.scan_voice]  <= '0;
    end else if (s2_v) begin
      pos_mem[s2_voice] <= s2_end ? 16'd0 : s2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      live   <= '0;
    end else if (cmd.claim) begin
      if (len_q != 16'd0) begin
        active[cmd.scan_voice] <= 1'b1;
        live <= live + 9'd1;
      end
    end else if (s2_v && s2_end && !s2_loop) begin
      active[s2_voice] <= 1'b0;
      live <= live - 9'd1;
    end
  end

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  logic claimed;
  always_ff @(posedge clk) begin
    if (rst) claimed <= 1'b0;
    else if (cmd.capture) claimed <= 1'b0;
    else if (cmd.claim) claimed <= 1'b1;
  end
  logic [7:0] slot_q;
  always_ff @(posedge clk) if (cmd.claim) slot_q <= cmd.scan_voice;

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      left_sample    <= (op_q == OP_TICK) ? sat24(sum_l) : '0;
      right_sample   <= (op_q == OP_TICK && stereo) ? sat24(sum_r) : '0;
      start_accepted <= (op_q == OP_START) && claimed;
      voice_slot     <= ((op_q == OP_START) && claimed) ? slot_q : '0;
      active_voices  <= live;
    end
  end
endmodule
`default_nettype wire

[hdl/svm_control.sv]
`default_nettype none
module svm_control (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       operation,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output svm_pkg::cmd_t         cmd,
  input  wire svm_pkg::status_t status
);
  import svm_pkg::*;

  state_t state, state_next;
  logic [8:0] idx, idx_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.scan_voice = idx[VoiceBits-1:0];
    in_stall       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = out_valid && out_stall;
        if (in_valid && !in_stall) begin
          cmd.capture    = 1'b1;
          cmd.clear_sums = 1'b1;
          cmd.load       = (operation == OP_LOAD);
          idx_next       = '0;
          unique case (operation)
            OP_START: state_next = ST_SEARCH;
            OP_TICK:  state_next = ST_TICK;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (idx[8]) state_next = ST_DONE;
        else if (!status.active) begin
          cmd.claim  = 1'b1;
          state_next = ST_DONE;
        end else idx_next = idx + 9'd1;
      end
      ST_TICK: begin
        cmd.scan_en = 1'b1;
        idx_next    = idx + 9'd1;
        if (idx == 9'(VoiceCount - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.scan_voice = '0;
        if (!status.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!(out_valid && out_stall)) begin
          cmd.done       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hdl/sample_voice_mixer.sv]
// Channel  Handshake              Payload
// in       in_valid / in_stall    operation, load_address, sample_value, sound_base, ...
// out      out_valid / out_stall  left_sample, right_sample, start_accepted, ...
// cfg      cfg_write              cfg_index, cfg_data
// A load or no-op goes straight to the result; a start searches the slots, one slot a cycle,
// and a tick scans all 256 voices, then the four-stage read/multiply pipe drains.
// Reset clears all voices and presets the registers; sample memory is not cleared.
// A stalled result holds the block; a new item is taken once the result leaves.
`default_nettype none
module sample_voice_mixer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [15:0]        load_address,
  input  wire logic signed [15:0] sample_value,
  input  wire logic [15:0]        sound_base,
  input  wire logic [15:0]        frame_count,
  input  wire logic [3:0]         sound_channels,
  input  wire logic               loop_flag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      left_sample,
  output logic signed [23:0]      right_sample,
  output logic                    start_accepted,
  output logic [7:0]              voice_slot,
  output logic [8:0]              active_voices,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import svm_pkg::*;

  cmd_t cmd;
  status_t status;
  logic [1:0]  out_channels;
  logic [15:0] mix_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_channels <= 2'd2;
      mix_gain     <= 16'd6554;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OUT_CHANNELS: out_channels <= cfg_data[1:0];
        REG_MIX_GAIN:     mix_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  svm_control u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .operation, .out_valid, .out_stall,
    .cmd, .status
  );

  svm_datapath u_dp (
    .clk, .rst, .cmd, .status, .out_channels, .mix_gain, .operation,
    .load_address, .sample_value, .sound_base, .frame_count, .sound_channels,
    .loop_flag, .left_sample, .right_sample, .start_accepted, .voice_slot,
    .active_voices
  );
endmodule
`default_nettype wire

[hdl/svm_checker.sv]
`default_nettype none
module svm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        start_accepted,
  input wire logic [7:0]  voice_slot,
  input wire logic [8:0]  active_voices,
  input wire logic signed [23:0] right_sample
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(active_voices) && $stable(right_sample))
    else $error("result dropped while stalled");
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !start_accepted |-> voice_slot == 8'd0)
    else $error("slot without accepted start");
  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && in_valid |-> in_stall)
    else $error("item taken with result pending");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> active_voices <= 9'd256)
    else $error("voice count out of range");
endmodule

bind sample_voice_mixer svm_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .start_accepted,
  .voice_slot, .active_voices, .right_sample
);
`default_nettype wire
